@@ hdl/bcs_pkg.sv @@
`timescale 1ns / 1ps

package bcs_pkg;

    localparam int PRICE_BITS   = 32;
    localparam int MAX_LOOKBACK = 64;
    localparam int HIST_AW      = $clog2(MAX_LOOKBACK);
    localparam int LB_BITS      = 7;
    localparam int QTY_BITS     = 7;
    localparam int SIG_BITS     = 2;

    localparam logic [LB_BITS-1:0]  LOOKBACK_RESET = LB_BITS'(20);
    localparam logic [LB_BITS-1:0]  LOOKBACK_MAX   = LB_BITS'(MAX_LOOKBACK);
    localparam logic [QTY_BITS-1:0] ORDER_QTY      = QTY_BITS'(100);

    localparam logic [SIG_BITS-1:0] SIG_NEUTRAL = 2'd0;
    localparam logic [SIG_BITS-1:0] SIG_BUY     = 2'd1;
    localparam logic [SIG_BITS-1:0] SIG_SELL    = 2'd2;

endpackage

@@ hdl/breakout_channel_signal_core.sv @@
`timescale 1ns / 1ps

// Channel   Ports                          Direction  Payload
// input     s_valid / s_ready              in         s_price
// result    m_valid / m_ready              out        signal, levels, order fields
// config    cfg_valid / cfg_ready          in         cfg_data (lookback period)
//
// Each beat is processed in full before the next is accepted. With the window full, the
// states READ, LAST and FINISH follow acceptance: READ reads back the L newest stored prices,
// L being the effective lookback, LAST folds in the final read, and FINISH loads the result.
// A beat before the window is full goes from acceptance straight to FINISH.
// READ is paced by the single read port of the price ring and the one compare unit,
// which handle one stored price per cycle.
// Reset clears the ring pointer and the fill count and returns the lookback period to 20;
// the ring itself is not cleared. A stalled result holds the block in its final state until
// it is taken.

module breakout_channel_signal_core
    import bcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LB_BITS-1:0]    cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PRICE_BITS-1:0] s_price,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SIG_BITS-1:0]   m_signal,
    output logic [PRICE_BITS-1:0] m_resistance,
    output logic [PRICE_BITS-1:0] m_support,
    output logic                  m_window_full,
    output logic [PRICE_BITS-1:0] m_order_price,
    output logic [QTY_BITS-1:0]   m_order_quantity
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [LB_BITS-1:0]      lookback_reg;
    logic [HIST_AW-1:0]      wr_index_reg;
    logic [LB_BITS-1:0]      fill_count_reg;
    logic [LB_BITS-1:0]      k_reg;
    logic [PRICE_BITS-1:0]   cur_reg;
    logic                    full_reg;
    logic                    pend_reg;
    logic                    pend_first_reg;
    logic [PRICE_BITS-1:0]   hi_reg;
    logic [PRICE_BITS-1:0]   lo_reg;
    logic [PRICE_BITS-1:0]   rd_data_reg;

    logic                    m_valid_reg;
    logic [SIG_BITS-1:0]     m_signal_reg;
    logic [PRICE_BITS-1:0]   m_resistance_reg;
    logic [PRICE_BITS-1:0]   m_support_reg;
    logic                    m_window_full_reg;
    logic [PRICE_BITS-1:0]   m_order_price_reg;
    logic [QTY_BITS-1:0]     m_order_quantity_reg;

    logic [PRICE_BITS-1:0]   history [MAX_LOOKBACK];

    logic [LB_BITS-1:0]      eff_lookback;
    logic [HIST_AW-1:0]      rd_addr;
    logic                    rd_en;
    logic                    wr_en;
    logic                    out_free;
    logic [PRICE_BITS-1:0]   hi_next;
    logic [PRICE_BITS-1:0]   lo_next;
    logic [SIG_BITS-1:0]     sig_next;

    always_comb begin
        if (lookback_reg == '0) begin
            eff_lookback = LB_BITS'(1);
        end else if (lookback_reg > LOOKBACK_MAX) begin
            eff_lookback = LOOKBACK_MAX;
        end else begin
            eff_lookback = lookback_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = (state_reg == ST_READ);
    assign rd_addr  = wr_index_reg - k_reg[HIST_AW-1:0];
    assign wr_en    = (state_reg == ST_FINISH) && out_free;

    // The compare unit folds the previous cycle's ring read into the running extremes.
    always_comb begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (pend_reg) begin
            if (pend_first_reg || rd_data_reg > hi_reg) begin
                hi_next = rd_data_reg;
            end
            if (pend_first_reg || rd_data_reg < lo_reg) begin
                lo_next = rd_data_reg;
            end
        end
    end

    always_comb begin
        sig_next = SIG_NEUTRAL;
        if (full_reg) begin
            if (cur_reg > hi_reg) begin
                sig_next = SIG_BUY;
            end else if (cur_reg < lo_reg) begin
                sig_next = SIG_SELL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            history[wr_index_reg] <= cur_reg;
        end
        if (rd_en) begin
            rd_data_reg <= history[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            lookback_reg   <= LOOKBACK_RESET;
            wr_index_reg   <= '0;
            fill_count_reg <= '0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
            pend_first_reg <= 1'b0;
            full_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                lookback_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            pend_reg       <= rd_en;
            pend_first_reg <= rd_en && (k_reg == LB_BITS'(1));
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cur_reg  <= s_price;
                        full_reg <= (fill_count_reg >= eff_lookback);
                        k_reg    <= LB_BITS'(1);
                        if (fill_count_reg >= eff_lookback) begin
                            state_reg <= ST_READ;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_READ: begin
                    if (k_reg == eff_lookback) begin
                        state_reg <= ST_LAST;
                    end else begin
                        k_reg <= k_reg + LB_BITS'(1);
                    end
                end
                ST_LAST: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        m_signal_reg         <= sig_next;
                        m_resistance_reg     <= full_reg ? hi_reg : '0;
                        m_support_reg        <= full_reg ? lo_reg : '0;
                        m_window_full_reg    <= full_reg;
                        m_order_price_reg    <= cur_reg;
                        m_order_quantity_reg <= (sig_next != SIG_NEUTRAL) ? ORDER_QTY : '0;
                        wr_index_reg         <= wr_index_reg + HIST_AW'(1);
                        if (fill_count_reg < LOOKBACK_MAX) begin
                            fill_count_reg <= fill_count_reg + LB_BITS'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready        = 1'b1;
    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_signal         = m_signal_reg;
    assign m_resistance     = m_resistance_reg;
    assign m_support        = m_support_reg;
    assign m_window_full    = m_window_full_reg;
    assign m_order_price    = m_order_price_reg;
    assign m_order_quantity = m_order_quantity_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_signal != SIG_NEUTRAL) == (m_order_quantity == ORDER_QTY)))
        else $error("Order quantity does not follow the signal.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_window_full) |->
            (m_signal == SIG_NEUTRAL && m_resistance == '0 && m_support == '0))
        else $error("Levels or signal set before the window is full.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_signal == SIG_BUY) |-> (m_order_price > m_resistance))
        else $error("Buy signal without a breakout above resistance.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_window_full) |-> (m_support <= m_resistance))
        else $error("Support above resistance.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= LOOKBACK_MAX)
        else $error("Fill count beyond the ring depth.");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bcs_pkg::*;

    typedef struct {
        logic [SIG_BITS-1:0]   signal;
        logic [PRICE_BITS-1:0] resistance;
        logic [PRICE_BITS-1:0] support;
        logic                  window_full;
        logic [PRICE_BITS-1:0] order_price;
        logic [QTY_BITS-1:0]   order_quantity;
    } breakout_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LB_BITS-1:0]    cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PRICE_BITS-1:0] s_price = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [SIG_BITS-1:0]   m_signal;
    logic [PRICE_BITS-1:0] m_resistance;
    logic [PRICE_BITS-1:0] m_support;
    logic                  m_window_full;
    logic [PRICE_BITS-1:0] m_order_price;
    logic [QTY_BITS-1:0]   m_order_quantity;

    logic [PRICE_BITS-1:0] price_backlog[$];
    breakout_t             awaited_breakouts[$];
    int                    mismatch_count = 0;
    int                    sender_idle_pct = 0;
    int                    receiver_stall_pct = 0;
    bit                    hold_request = 1'b0;
    logic                  hold_off = 1'b0;

    // Own copy of the block state, advanced once per accepted price beat.
    logic [PRICE_BITS-1:0] ring_prices[MAX_LOOKBACK];
    logic [HIST_AW-1:0]    ring_head = '0;
    int                    ring_fill = 0;
    logic [LB_BITS-1:0]    lookback_reg = LOOKBACK_RESET;
    logic [PRICE_BITS-1:0] walk_price = PRICE_BITS'(1_000_000);

    breakout_channel_signal_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_price          (s_price),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_signal         (m_signal),
        .m_resistance     (m_resistance),
        .m_support        (m_support),
        .m_window_full    (m_window_full),
        .m_order_price    (m_order_price),
        .m_order_quantity (m_order_quantity)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic breakout_t predict_breakout(input logic [PRICE_BITS-1:0] price);
        breakout_t          r;
        int                 win;
        logic [HIST_AW-1:0] slot;
        logic [PRICE_BITS-1:0] held;
        win = (lookback_reg == '0) ? 1 : int'(lookback_reg);
        if (win > MAX_LOOKBACK) win = MAX_LOOKBACK;
        r.signal = SIG_NEUTRAL;
        r.resistance = '0;
        r.support = '0;
        r.window_full = (ring_fill >= win);
        r.order_price = price;
        if (r.window_full) begin
            for (int k = 1; k <= win; k++) begin
                slot = ring_head - HIST_AW'(k);
                held = ring_prices[slot];
                if (k == 1 || held > r.resistance) r.resistance = held;
                if (k == 1 || held < r.support) r.support = held;
            end
            if (price > r.resistance) begin
                r.signal = SIG_BUY;
            end else if (price < r.support) begin
                r.signal = SIG_SELL;
            end
        end
        r.order_quantity = (r.signal != SIG_NEUTRAL) ? ORDER_QTY : '0;
        ring_prices[ring_head] = price;
        ring_head = ring_head + HIST_AW'(1);
        if (ring_fill < MAX_LOOKBACK) ring_fill++;
        return r;
    endfunction

    // Mostly a random walk, so that breakouts and ties occur, with jumps to the extremes.
    function automatic logic [PRICE_BITS-1:0] random_price();
        int     pick;
        longint moved;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            walk_price = '0;
        end else if (pick < 6) begin
            walk_price = '1;
        end else if (pick < 12) begin
            walk_price = $urandom;
        end else if (pick >= 22) begin
            moved = longint'(walk_price) + longint'($urandom_range(0, 6000)) - 3000;
            if (moved < 0) begin
                moved = 0;
            end else if (moved > 64'sd4294967295) begin
                moved = 64'sd4294967295;
            end
            walk_price = moved[PRICE_BITS-1:0];
        end
        return walk_price;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [PRICE_BITS-1:0] got,
                               input logic [PRICE_BITS-1:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Driver: one nonblocking assignment per signal per edge.
    always @(posedge aclk) begin
        logic                  next_valid;
        logic [PRICE_BITS-1:0] next_price;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            next_price = s_price;
            if (s_valid && s_ready) begin
                awaited_breakouts.push_back(predict_breakout(s_price));
                next_valid = 1'b0;
            end
            if (!next_valid && price_backlog.size() != 0
                    && $urandom_range(0, 99) >= sender_idle_pct) begin
                next_valid = 1'b1;
                next_price = price_backlog.pop_front();
            end
            s_valid <= next_valid;
            s_price <= next_price;
        end
    end

    // Monitor: compares every result beat with the oldest prediction.
    always @(posedge aclk) begin
        breakout_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_breakouts.size() == 0) begin
                    report_mismatch("result beat with no price outstanding");
                end else begin
                    want = awaited_breakouts.pop_front();
                    check_field("signal", PRICE_BITS'(m_signal), PRICE_BITS'(want.signal));
                    check_field("resistance", m_resistance, want.resistance);
                    check_field("support", m_support, want.support);
                    check_field("window_full", PRICE_BITS'(m_window_full),
                                PRICE_BITS'(want.window_full));
                    check_field("order_price", m_order_price, want.order_price);
                    check_field("order_quantity", PRICE_BITS'(m_order_quantity),
                                PRICE_BITS'(want.order_quantity));
                end
            end
            m_ready <= !hold_off && ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Long hold-off of the result channel whilst prices keep arriving.
    initial begin
        wait (hold_request);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (price_backlog.size() != 0 || s_valid || awaited_breakouts.size() != 0);
    endtask

    task automatic write_lookback(input logic [LB_BITS-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        lookback_reg = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [LB_BITS-1:0] lookback, input int idle_pct,
                             input int stall_pct, input int count, input bit with_hold);
        wait_drained();
        write_lookback(lookback);
        @(negedge aclk);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) price_backlog.push_back(random_price());
        if (with_hold) hold_request = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // The window of twenty fills first, then a breakout, a breakdown and a tie.
        for (int i = 0; i < 20; i++) price_backlog.push_back(PRICE_BITS'(50000 + 37 * i));
        price_backlog.push_back(PRICE_BITS'(60000));
        price_backlog.push_back(PRICE_BITS'(100));
        price_backlog.push_back(PRICE_BITS'(60000));
        wait_drained();
        // A lookback of zero acts as one; the price extremes are driven here.
        write_lookback('0);
        price_backlog.push_back('0);
        price_backlog.push_back('1);
        price_backlog.push_back('1);

        run_phase(LB_BITS'(127), 0, 0, 100, 1'b0);
        run_phase(LB_BITS'(1), 50, 0, 100, 1'b0);
        run_phase(LB_BITS'(64), 0, 50, 100, 1'b0);
        run_phase(LB_BITS'(65), 28, 28, 80, 1'b0);
        run_phase(LB_BITS'(5), 0, 0, 100, 1'b1);
        run_phase(LB_BITS'($urandom_range(0, 127)), 50, 0, 100, 1'b0);
        run_phase(LB_BITS'(2), 0, 50, 100, 1'b0);
        run_phase(LB_BITS'(33), 28, 28, 100, 1'b0);

        wait_drained();
        repeat (80) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bcs_pkg.sv
hdl/breakout_channel_signal_core.sv
tb/sv/testbench.sv
